@@ src/bde_pkg.sv @@
// shared constants, word types and control structs for the 3x3 binary morphology block
package bde_pkg;

	// frame limits
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	// field and counter widths
	localparam int CFG_W   = 11;
	localparam int TOT_W   = 21;
	localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WID_W   = $clog2(MAX_WIDTH + 1);
	localparam int HGT_W   = $clog2(MAX_HEIGHT + 1);
	localparam int LAG_W   = $clog2(MAX_WIDTH + 2);

	// three row banks, selected by row modulo three
	localparam int NUM_BANKS = 3;
	localparam int BANK_W    = 2;

	typedef logic [BANK_W-1:0] bank_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_MODE   = 2'd2
	} cfg_index_t;

	// input word opcodes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef struct packed {
		logic opcode;
		logic pixel_in;
	} in_word_t;

	typedef struct packed {
		logic             pixel_out;
		logic             pixel_changed;
		logic             frame_last;
		logic [TOT_W-1:0] changed_total;
	} out_word_t;

	// row store access for one accepted word
	typedef struct packed {
		logic [NUM_BANKS-1:0] we;
		logic [COL_W-1:0]     waddr;
		logic                 wdata;
		logic                 re;
		logic [COL_W-1:0]     raddr_mid;
		logic [COL_W-1:0]     raddr_right;
	} store_req_t;

	// window assembly info for one output pixel
	typedef struct packed {
		bank_t top_bank;
		bank_t mid_bank;
		bank_t bot_bank;
		logic  bypass;
		logic  first_col;
		logic  last_col;
		logic  frame_last;
	} emit_ctl_t;

endpackage

@@ src/bde_bank.sv @@
// one row bank of the line store: one write port, two registered read ports
module bde_bank (
	input  logic                      clk,
	input  logic                      we,
	input  logic [bde_pkg::COL_W-1:0] waddr,
	input  logic                      wdata,
	input  logic                      re,
	input  logic [bde_pkg::COL_W-1:0] raddr_a,
	input  logic [bde_pkg::COL_W-1:0] raddr_b,
	output logic                      rdata_a,
	output logic                      rdata_b
);
	import bde_pkg::*;

	logic mem [MAX_WIDTH];
	logic rdata_a_s1;
	logic rdata_b_s1;

	// write and read, reads return the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a_s1 <= mem[raddr_a];
			rdata_b_s1 <= mem[raddr_b];
		end
	end

	assign rdata_a = rdata_a_s1;
	assign rdata_b = rdata_b_s1;

endmodule

@@ src/bde_ctrl.sv @@
// configuration registers, raster counters and output scheduling
module bde_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [bde_pkg::CFG_W-1:0] cfg_data,
	input  logic                      accept,
	input  bde_pkg::in_word_t         word,
	output bde_pkg::store_req_t       store_req,
	output logic                      emit,
	output bde_pkg::emit_ctl_t        emit_ctl,
	output logic                      dilate_mode,
	output logic                      restart
);
	import bde_pkg::*;

	// configuration
	logic [WID_W-1:0] w_q;
	logic [COL_W-1:0] wm1_q;
	logic [ROW_W-1:0] hm1_q;
	logic             mode_q;

	// write position
	logic [COL_W-1:0] wx_q;
	logic [ROW_W-1:0] wy_q;
	bank_t            wbank_q;
	logic             rx_done_q;
	logic [LAG_W-1:0] lag_q;

	// output position
	logic [COL_W-1:0] ex_q;
	logic [ROW_W-1:0] ey_q;
	bank_t            ebank_q;

	logic [WID_W-1:0] cfg_w;
	logic [HGT_W-1:0] cfg_h;
	logic             is_pixel;
	logic             wr_pix;
	logic             last_col;
	logic             first_row;
	logic             last_row;
	logic             frame_end;

	function automatic bank_t bank_next(input bank_t b);
		bank_t r;
		r = (b == BANK_W'(NUM_BANKS - 1)) ? '0 : b + BANK_W'(1);
		return r;
	endfunction

	function automatic bank_t bank_prev(input bank_t b);
		bank_t r;
		r = (b == '0) ? BANK_W'(NUM_BANKS - 1) : b - BANK_W'(1);
		return r;
	endfunction

	// clamp the written dimensions into range
	always_comb begin
		if (cfg_data == '0) begin
			cfg_w = WID_W'(1);
		end else if (int'(cfg_data) > MAX_WIDTH) begin
			cfg_w = WID_W'(MAX_WIDTH);
		end else begin
			cfg_w = WID_W'(cfg_data);
		end
		if (cfg_data == '0) begin
			cfg_h = HGT_W'(1);
		end else if (int'(cfg_data) > MAX_HEIGHT) begin
			cfg_h = HGT_W'(MAX_HEIGHT);
		end else begin
			cfg_h = HGT_W'(cfg_data);
		end
	end

	// register decode, any known register write restarts the frame
	always_comb begin
		restart = 1'b0;
		if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIDTH, CFG_HEIGHT, CFG_MODE: restart = 1'b1;
				default:                         restart = 1'b0;
			endcase
		end
	end

	// scheduling decision for the accepted word
	always_comb begin
		is_pixel  = (word.opcode == OP_PIXEL);
		wr_pix    = accept && is_pixel && !rx_done_q;
		emit      = accept && (is_pixel ? (!rx_done_q && (lag_q > LAG_W'(w_q))) : rx_done_q);
		last_col  = (ex_q == wm1_q);
		first_row = (ey_q == '0);
		last_row  = (ey_q == hm1_q);
		frame_end = emit && last_col && last_row;
	end

	// window rows for the output pixel, clamped at top and bottom
	always_comb begin
		emit_ctl.top_bank   = first_row ? ebank_q : bank_prev(ebank_q);
		emit_ctl.mid_bank   = ebank_q;
		emit_ctl.bot_bank   = last_row ? ebank_q : bank_next(ebank_q);
		emit_ctl.bypass     = is_pixel;
		emit_ctl.first_col  = (ex_q == '0);
		emit_ctl.last_col   = last_col;
		emit_ctl.frame_last = last_row && last_col;
	end

	// line store access
	always_comb begin
		for (int i = 0; i < NUM_BANKS; i++) begin
			store_req.we[i] = wr_pix && (wbank_q == BANK_W'(i));
		end
		store_req.waddr       = wx_q;
		store_req.wdata       = word.pixel_in;
		store_req.re          = emit;
		store_req.raddr_mid   = ex_q;
		store_req.raddr_right = ex_q + COL_W'(1);
	end

	assign dilate_mode = mode_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= WID_W'(1);
			wm1_q  <= '0;
			hm1_q  <= '0;
			mode_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIDTH: begin
					w_q   <= cfg_w;
					wm1_q <= COL_W'(cfg_w - WID_W'(1));
				end
				CFG_HEIGHT: begin
					hm1_q <= ROW_W'(cfg_h - HGT_W'(1));
				end
				CFG_MODE: begin
					mode_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// raster counters, cleared on restart and after the frame's last output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wx_q      <= '0;
			wy_q      <= '0;
			wbank_q   <= '0;
			rx_done_q <= 1'b0;
			lag_q     <= '0;
			ex_q      <= '0;
			ey_q      <= '0;
			ebank_q   <= '0;
		end else if (restart || frame_end) begin
			wx_q      <= '0;
			wy_q      <= '0;
			wbank_q   <= '0;
			rx_done_q <= 1'b0;
			lag_q     <= '0;
			ex_q      <= '0;
			ey_q      <= '0;
			ebank_q   <= '0;
		end else begin
			// input side
			if (wr_pix) begin
				if (wx_q == wm1_q) begin
					wx_q    <= '0;
					wbank_q <= bank_next(wbank_q);
					if (wy_q == hm1_q) begin
						rx_done_q <= 1'b1;
					end else begin
						wy_q <= wy_q + ROW_W'(1);
					end
				end else begin
					wx_q <= wx_q + COL_W'(1);
				end
			end
			// distance between input and output positions
			if (wr_pix && !emit) begin
				lag_q <= lag_q + LAG_W'(1);
			end else if (!wr_pix && emit) begin
				lag_q <= lag_q - LAG_W'(1);
			end
			// output side
			if (emit) begin
				if (last_col) begin
					ex_q    <= '0;
					ey_q    <= ey_q + ROW_W'(1);
					ebank_q <= bank_next(ebank_q);
				end else begin
					ex_q <= ex_q + COL_W'(1);
				end
			end
		end
	end

endmodule

@@ src/bde_window.sv @@
// 3x3 window assembly, morphology result, change tally and output register
module bde_window (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  bde_pkg::emit_ctl_t            ctl,
	input  logic                          pixel_in,
	input  logic [bde_pkg::NUM_BANKS-1:0] mid_col,
	input  logic [bde_pkg::NUM_BANKS-1:0] right_col,
	input  logic                          dilate_mode,
	input  logic                          restart,
	output logic                          ready,
	output logic                          res_valid,
	input  logic                          res_ready,
	output bde_pkg::out_word_t            res_data
);
	import bde_pkg::*;

	logic             valid_s1;
	emit_ctl_t        ctl_s1;
	logic             pix_s1;
	logic             res_valid_s2;
	out_word_t        res_word_s2;
	logic [2:0]       prev_mid_q;
	logic [TOT_W-1:0] tally_q;

	logic             adv;
	logic [2:0]       col_left;
	logic [2:0]       col_mid;
	logic [2:0]       col_right_raw;
	logic [2:0]       col_right;
	logic [8:0]       win;
	logic             res;
	logic             chg;
	logic [TOT_W-1:0] tally_next;

	// stage handshake
	assign adv   = valid_s1 && (!res_valid_s2 || res_ready);
	assign ready = !valid_s1 || adv;

	// columns top to bottom, clamped at the row ends
	always_comb begin
		col_mid       = {mid_col[ctl_s1.top_bank], mid_col[ctl_s1.mid_bank],
		                 mid_col[ctl_s1.bot_bank]};
		col_right_raw = {right_col[ctl_s1.top_bank], right_col[ctl_s1.mid_bank],
		                 ctl_s1.bypass ? pix_s1 : right_col[ctl_s1.bot_bank]};
		col_right     = ctl_s1.last_col ? col_mid : col_right_raw;
		col_left      = ctl_s1.first_col ? col_mid : prev_mid_q;
		win           = {col_left, col_mid, col_right};
	end

	// dilation is any one in the window, erosion is all ones
	always_comb begin
		res        = dilate_mode ? (|win) : (&win);
		chg        = res ^ col_mid[1];
		tally_next = tally_q + TOT_W'(chg);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			res_valid_s2 <= 1'b0;
			tally_q      <= '0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				res_valid_s2 <= 1'b1;
			end else if (res_ready) begin
				res_valid_s2 <= 1'b0;
			end
			if (restart) begin
				tally_q <= '0;
			end else if (adv) begin
				tally_q <= ctl_s1.frame_last ? '0 : tally_next;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (load) begin
			ctl_s1 <= ctl;
			pix_s1 <= pixel_in;
		end
		if (adv) begin
			prev_mid_q                <= col_mid;
			res_word_s2.pixel_out     <= res;
			res_word_s2.pixel_changed <= chg;
			res_word_s2.frame_last    <= ctl_s1.frame_last;
			res_word_s2.changed_total <= ctl_s1.frame_last ? tally_next : '0;
		end
	end

	assign res_valid = res_valid_s2;
	assign res_data  = res_word_s2;

endmodule

@@ src/binary_dilate_erode_3x3.sv @@
// top level of the streaming 3x3 binary dilation and erosion block
// Takes a binary frame in raster order, one pixel word per clock while the
// output is not stalled, and gives at most one dilated (dilate_mode 1) or
// eroded (dilate_mode 0) pixel per word, with edge pixels replicated at the
// frame borders. The result for raster position k comes out with input
// pixel k+width+1; drain words flush the frame's remaining results, and the
// last result of a frame carries its count of changed pixels. The line store
// reads are registered when a word is accepted, the window logic fills the
// output register from them, and the result leaves from that register. The
// line store is three row banks of MAX_WIDTH one-bit entries, each with one
// write and two read ports; it needs no clearing after reset. Register writes
// restart the frame; the user must make them only while the block is idle,
// as the block itself does not enforce it.
module binary_dilate_erode_3x3 (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [bde_pkg::CFG_W-1:0] cfg_data,
	input  logic                      pix_valid,
	output logic                      pix_ready,
	input  bde_pkg::in_word_t         pix_data,
	output logic                      res_valid,
	input  logic                      res_ready,
	output bde_pkg::out_word_t        res_data
);
	import bde_pkg::*;

	logic                 accept;
	store_req_t           store_req;
	logic                 emit;
	emit_ctl_t            emit_ctl;
	logic                 dilate_mode;
	logic                 restart;
	logic [NUM_BANKS-1:0] mid_col;
	logic [NUM_BANKS-1:0] right_col;

	assign accept = pix_valid && pix_ready;

	// counters and scheduling
	bde_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.word        (pix_data),
		.store_req   (store_req),
		.emit        (emit),
		.emit_ctl    (emit_ctl),
		.dilate_mode (dilate_mode),
		.restart     (restart)
	);

	// line store, one bank per row modulo three
	for (genvar i = 0; i < NUM_BANKS; i++) begin : g_bank
		bde_bank u_bank (
			.clk     (clk),
			.we      (store_req.we[i]),
			.waddr   (store_req.waddr),
			.wdata   (store_req.wdata),
			.re      (store_req.re),
			.raddr_a (store_req.raddr_mid),
			.raddr_b (store_req.raddr_right),
			.rdata_a (mid_col[i]),
			.rdata_b (right_col[i])
		);
	end

	// window logic and output register
	bde_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (emit),
		.ctl         (emit_ctl),
		.pixel_in    (pix_data.pixel_in),
		.mid_col     (mid_col),
		.right_col   (right_col),
		.dilate_mode (dilate_mode),
		.restart     (restart),
		.ready       (pix_ready),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res_data    (res_data)
	);

endmodule

@@ dv/binary_dilate_erode_3x3_test.sv @@
// self-checking testbench for the streaming 3x3 binary dilation and erosion block
`timescale 1ns / 100ps

class pixel_scoreboard;
	localparam int RING_DEPTH = 2 * bde_pkg::MAX_WIDTH + 4;

	// register copies
	logic [bde_pkg::CFG_W-1:0] width_reg;
	logic [bde_pkg::CFG_W-1:0] height_reg;
	logic                      dilate;

	// frame state: raster-indexed ring of source pixels and counters
	bit                        ring_bits [RING_DEPTH];
	int                        received;
	int                        emitted;
	logic [bde_pkg::TOT_W-1:0] tally;

	bde_pkg::out_word_t        expected_pixels [$];
	int                        errors;
	int                        checked;
	int                        frames_done;

	function new();
		width_reg   = bde_pkg::CFG_W'(1);
		height_reg  = bde_pkg::CFG_W'(1);
		dilate      = 1'b1;
		received    = 0;
		emitted     = 0;
		tally       = '0;
		errors      = 0;
		checked     = 0;
		frames_done = 0;
	endfunction

	// zero reads as one, anything above the limit saturates
	function int clamp_size(int value, int limit);
		if (value == 0)
			return 1;
		if (value > limit)
			return limit;
		return value;
	endfunction

	function int clamp_coord(int value, int limit);
		if (value < 0)
			return 0;
		if (value >= limit)
			return limit - 1;
		return value;
	endfunction

	function int frame_width();
		return clamp_size(int'(width_reg), bde_pkg::MAX_WIDTH);
	endfunction

	function int frame_total();
		return frame_width() * clamp_size(int'(height_reg), bde_pkg::MAX_HEIGHT);
	endfunction

	function void restart_frame();
		received = 0;
		emitted  = 0;
		tally    = '0;
	endfunction

	// any register write restarts the frame, stored pixels stay
	function void set_reg(bde_pkg::cfg_index_t idx, logic [bde_pkg::CFG_W-1:0] value);
		case (idx)
			bde_pkg::CFG_WIDTH:  width_reg  = value;
			bde_pkg::CFG_HEIGHT: height_reg = value;
			bde_pkg::CFG_MODE:   dilate     = value[0];
			default: ;
		endcase
		restart_frame();
	endfunction

	// morphology result for the next raster position of the frame
	function bde_pkg::out_word_t compute_pixel();
		int                 w;
		int                 total;
		int                 rows;
		int                 x;
		int                 y;
		int                 pos;
		logic               hit;
		logic               res;
		logic               src;
		bde_pkg::out_word_t word;
		w     = frame_width();
		total = frame_total();
		rows  = total / w;
		x     = emitted % w;
		y     = emitted / w;
		hit   = 1'b0;
		// clamped window, edge pixels replicated
		for (int dy = -1; dy <= 1; dy++) begin
			for (int dx = -1; dx <= 1; dx++) begin
				pos = clamp_coord(y + dy, rows) * w + clamp_coord(x + dx, w);
				if (ring_bits[pos % RING_DEPTH] == dilate)
					hit = 1'b1;
			end
		end
		res     = hit ? dilate : ~dilate;
		src     = ring_bits[emitted % RING_DEPTH];
		tally   = tally + (res != src);
		emitted = emitted + 1;
		word.pixel_out     = res;
		word.pixel_changed = (res != src);
		word.frame_last    = (emitted >= total);
		word.changed_total = word.frame_last ? tally : '0;
		if (word.frame_last) begin
			restart_frame();
			frames_done++;
		end
		return word;
	endfunction

	// accepted input word; returns 0 when the block simply drops it
	function bit take_word(bde_pkg::in_word_t word);
		int total;
		total = frame_total();
		if (word.opcode == bde_pkg::OP_PIXEL) begin
			if (received >= total)
				return 1'b0;
			ring_bits[received % RING_DEPTH] = word.pixel_in;
			received++;
			if (emitted < total && received >= emitted + frame_width() + 2)
				expected_pixels.push_back(compute_pixel());
			return 1'b1;
		end
		if (received >= total && emitted < total) begin
			expected_pixels.push_back(compute_pixel());
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// drain words still owed once the whole frame is in
	function int drains_owed();
		return (received >= frame_total()) ? frame_total() - emitted : 0;
	endfunction

	function void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch on result %0d, expected %0d, actual %0d",
				$time, name, checked, want, got);
			errors++;
		end
	endfunction

	// accepted output word against the oldest expectation
	function void check_pixel(bde_pkg::out_word_t got);
		bde_pkg::out_word_t want;
		if (expected_pixels.size() == 0) begin
			$display("%0t: result word %h with nothing expected", $time, got);
			errors++;
			return;
		end
		want = expected_pixels.pop_front();
		compare_field("pixel_out", 32'(want.pixel_out), 32'(got.pixel_out));
		compare_field("pixel_changed", 32'(want.pixel_changed), 32'(got.pixel_changed));
		compare_field("frame_last", 32'(want.frame_last), 32'(got.frame_last));
		compare_field("changed_total", 32'(want.changed_total), 32'(got.changed_total));
		checked++;
	endfunction
endclass

module binary_dilate_erode_3x3_test;
	import bde_pkg::*;

	localparam int PERIOD_NS     = 20;
	localparam int TIMEOUT_NS    = 10_000_000;
	localparam int SETTLE_CYCLES = 4;
	localparam int TARGET_WORDS  = 1650;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             pix_valid;
	logic             pix_ready;
	in_word_t         pix_data;
	logic             res_valid;
	logic             res_ready = 1'b0;
	out_word_t        res_data;

	pixel_scoreboard  board;
	bit               steady;
	int               words_sent;
	int               cfg_writes;

	binary_dilate_erode_3x3 u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix_data  (pix_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	always #(PERIOD_NS / 2) clk = ~clk;

	// result side: check accepted words, random backpressure
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			board.check_pixel(res_data);
		res_ready <= steady || ($urandom_range(99) >= 36);
	end

	// offer one word and hold it until taken
	task automatic send_word(input logic opcode, input logic pixel);
		in_word_t word;
		word.opcode   = opcode;
		word.pixel_in = pixel;
		while (!steady && $urandom_range(99) < 36) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pix_data  <= word;
		do
			@(posedge clk);
		while (!pix_ready);
		words_sent += int'(board.take_word(word));
	endtask

	// stop sending until every expected result is out
	task automatic wait_results_out();
		pix_valid <= 1'b0;
		do
			@(posedge clk);
		while (board.expected_pixels.size() != 0);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		board.set_reg(idx, value);
		cfg_writes++;
	endtask

	// idle the block, then write all registers or a random subset of them
	task automatic apply_config(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] height,
			input logic mode, input bit every);
		int pick;
		pick = every ? 7 : int'($urandom_range(1, 7));
		wait_results_out();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pick[0])
			write_reg(CFG_WIDTH, width);
		if (pick[1])
			write_reg(CFG_HEIGHT, height);
		if (pick[2])
			write_reg(CFG_MODE, {{(CFG_W - 1){1'b0}}, mode});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// mostly small sizes, some zero and one
	function automatic logic [CFG_W-1:0] pick_size(input int top);
		int r;
		r = int'($urandom_range(99));
		if (r < 5)
			return CFG_W'(0);
		if (r < 15)
			return CFG_W'(1);
		if (r < 85)
			return CFG_W'($urandom_range(2, top / 3));
		return CFG_W'($urandom_range(top / 3 + 1, top));
	endfunction

	// one frame of random pixels; cut 0 runs it whole with drains, -1 stops at random,
	// a positive cut stops after that many pixels
	task automatic run_frame(input int cut);
		int total;
		int stop;
		int density;
		int pause_at;
		total = board.frame_total();
		if (cut == 0)
			stop = total;
		else if (cut < 0)
			stop = int'($urandom_range(1, total));
		else
			stop = (cut < total) ? cut : total;
		density  = int'($urandom_range(5, 95));
		pause_at = ($urandom_range(3) == 0) ? int'($urandom_range(0, stop - 1)) : -1;
		for (int i = 0; i < stop; i++) begin
			// early drain, dropped while the frame is still coming in
			if ($urandom_range(99) < 4)
				send_word(OP_DRAIN, 1'($urandom_range(1)));
			send_word(OP_PIXEL, $urandom_range(99) < density);
			if (i == pause_at)
				wait_results_out();
		end
		if (cut != 0)
			return;
		// pixels past the frame end are dropped
		repeat (($urandom_range(99) < 30) ? $urandom_range(1, 3) : 0)
			send_word(OP_PIXEL, 1'($urandom_range(1)));
		repeat (board.drains_owed())
			send_word(OP_DRAIN, 1'($urandom_range(1)));
		// drains with nothing pending
		repeat ($urandom_range(2))
			send_word(OP_DRAIN, 1'($urandom_range(1)));
	endtask

	initial begin
		board      = new();
		steady     = 1'b0;
		words_sent = 0;
		cfg_writes = 0;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = CFG_WIDTH;
		cfg_data   = '0;
		pix_valid  = 1'b0;
		pix_data   = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one-pixel frame, dilation; last drain finds nothing pending
		send_word(OP_PIXEL, 1'b1);
		send_word(OP_DRAIN, 1'b0);
		send_word(OP_DRAIN, 1'b1);

		// zero sizes read as one, erosion; second pixel is past the frame end
		apply_config(CFG_W'(0), CFG_W'(0), 1'b0, 1'b1);
		send_word(OP_PIXEL, 1'b0);
		send_word(OP_PIXEL, 1'b1);
		send_word(OP_DRAIN, 1'b0);

		// 3x2 dilation: early drain, full frame, extra pixel, flush plus one idle drain
		apply_config(CFG_W'(3), CFG_W'(2), 1'b1, 1'b1);
		send_word(OP_DRAIN, 1'b0);
		for (int i = 0; i < 6; i++)
			send_word(OP_PIXEL, 1'(6'b010001 >> i));
		send_word(OP_PIXEL, 1'b1);
		repeat (5)
			send_word(OP_DRAIN, 1'b0);

		// random phases with two fixed extreme ones, both always reached
		for (int phase = 0; words_sent < TARGET_WORDS || phase <= 5; phase++) begin
			if (phase == 2) begin
				// both sizes saturated; a partial frame reaches the first results
				apply_config(11'h7FF, 11'h7FF, 1'($urandom_range(1)), 1'b1);
				run_frame(1040);
			end else if (phase == 5) begin
				// exact maximum height, one column, no idling on either side
				apply_config(CFG_W'(1), CFG_W'(MAX_HEIGHT), 1'($urandom_range(1)), 1'b1);
				steady = 1'b1;
				run_frame(150);
				wait_results_out();
				steady = 1'b0;
			end else begin
				apply_config(pick_size(24), pick_size(12), 1'($urandom_range(1)), phase < 2);
				repeat ($urandom_range(1, 3))
					run_frame(0);
				if ($urandom_range(3) == 0)
					run_frame(-1);
			end
		end

		wait_results_out();
		repeat (SETTLE_CYCLES * 4) @(posedge clk);

		$display("covered %0d effective words, %0d results checked, %0d frames closed",
			words_sent, board.checked, board.frames_done);
		$display("over %0d register writes: dilation and erosion, sizes zero to saturated",
			cfg_writes);
		if (board.expected_pixels.size() != 0)
			$display("%0t: %0d expected results never arrived", $time,
				board.expected_pixels.size());
		if (board.errors == 0 && board.expected_pixels.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// hard stop if the run hangs
	initial begin
		#(TIMEOUT_NS);
		$display("tb: failure");
		$finish;
	end

endmodule
